// ===== src/des_pkg.sv =====
// package for the disk elevator scheduler: item and result types, codes,
// controller states and the controller/datapath command and status groups
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package des_pkg;

  // default sizes
  localparam int unsigned MAX_REQUESTS_DEF = 32;
  localparam int unsigned CYL_BITS_DEF     = 16;

  // item command codes
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_RUN  = 1'b1;

  // saturation limits of the result fields
  localparam logic [31:0] STEP_MAX  = 32'h0000_FFFF;
  localparam logic [32:0] TOTAL_MAX = 33'h0_0001_FFFF;

  // one input item
  typedef struct packed {
    logic        cmd;
    logic [15:0] request_cylinder;
    logic [15:0] start_cylinder;
    logic        move_right;
  } in_t;

  // one result item
  typedef struct packed {
    logic [15:0] served_cylinder;
    logic [15:0] step_distance;
    logic [16:0] total_movement;
    logic        empty_run;
    logic        last;
  } out_t;

  // controller states
  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_DRAIN  = 4'b0100,
    ST_DECIDE = 4'b1000
  } state_e;

  // commands from controller to datapath
  typedef struct packed {
    logic load;
    logic run;
    logic scan_clr;
    logic scan_step;
    logic emit;
    logic switch_side;
  } ctrl_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic count_zero;
    logic rd_last;
    logic found;
    logic last_hit;
  } dp_stat_t;

endpackage

`default_nettype wire

// ===== src/des_ram.sv =====
// generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module des_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ===== src/des_ctrl.sv =====
// controller state machine of the disk elevator scheduler
// depends on des_pkg
`timescale 1ns / 1ps
`default_nettype none

module des_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic              item_cmd_i,
  input  wire des_pkg::dp_stat_t stat_i,
  output des_pkg::ctrl_cmd_t     cmd_o,
  output logic                   busy_o
);

  des_pkg::state_e state_q, state_d;

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      des_pkg::ST_IDLE: begin
        if (start_i) begin
          if (item_cmd_i == des_pkg::CMD_LOAD) begin
            cmd_o.load = 1'b1;
          end else begin
            cmd_o.run      = 1'b1;
            cmd_o.scan_clr = 1'b1;
            if (!stat_i.count_zero) begin
              state_d = des_pkg::ST_SCAN;
            end
          end
        end
      end
      des_pkg::ST_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (stat_i.rd_last) begin
          state_d = des_pkg::ST_DRAIN;
        end
      end
      des_pkg::ST_DRAIN: begin
        state_d = des_pkg::ST_DECIDE;
      end
      des_pkg::ST_DECIDE: begin
        if (stat_i.found) begin
          cmd_o.emit = 1'b1;
          if (stat_i.last_hit) begin
            state_d = des_pkg::ST_IDLE;
          end else begin
            cmd_o.scan_clr = 1'b1;
            state_d        = des_pkg::ST_SCAN;
          end
        end else begin
          // first side used up: turn around
          cmd_o.switch_side = 1'b1;
          cmd_o.scan_clr    = 1'b1;
          state_d           = des_pkg::ST_SCAN;
        end
      end
      default: begin
        state_d = des_pkg::ST_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= des_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != des_pkg::ST_IDLE);

endmodule

`default_nettype wire

// ===== src/des_dp.sv =====
// datapath of the disk elevator scheduler: request ram, scan for the next
// request to serve, seek distance and running total, result register
// depends on des_pkg and des_ram
`timescale 1ns / 1ps
`default_nettype none

module des_dp #(
  parameter int unsigned MAX_REQUESTS = des_pkg::MAX_REQUESTS_DEF,
  parameter int unsigned CYL_BITS     = des_pkg::CYL_BITS_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire des_pkg::in_t       item_i,
  input  wire des_pkg::ctrl_cmd_t cmd_i,
  output des_pkg::dp_stat_t       stat_o,
  output des_pkg::out_t           result_o,
  output logic                    result_valid_o
);

  localparam int unsigned AW = $clog2(MAX_REQUESTS);
  localparam int unsigned CW = $clog2(MAX_REQUESTS + 1);

  logic [CW-1:0]           count_q;
  logic [CW-1:0]           n_q;
  logic [CW-1:0]           served_cnt_q;
  logic [MAX_REQUESTS-1:0] served_q;
  logic [AW-1:0]           rd_idx_q;
  logic [AW-1:0]           eval_idx_q;
  logic                    eval_vld_q;
  logic                    found_q;
  logic [CYL_BITS-1:0]     best_q;
  logic [AW-1:0]           best_idx_q;
  logic [CYL_BITS-1:0]     start_q;
  logic [CYL_BITS-1:0]     head_q;
  logic                    side_q;
  logic [16:0]             total_q;
  des_pkg::out_t           result_q;
  logic                    valid_q;

  logic [CYL_BITS-1:0] rdata;
  logic [31:0]         req_ext;
  logic [31:0]         start_ext;
  logic                ram_we;
  logic                cand;
  logic [CYL_BITS-1:0] seek_dist;
  logic [31:0]         dist_ext;
  logic [31:0]         best_ext;
  logic [32:0]         sum;
  logic [15:0]         step_d;
  logic [16:0]         total_d;

  // input cylinders cut to the configured width
  assign req_ext   = 32'(item_i.request_cylinder);
  assign start_ext = 32'(item_i.start_cylinder);
  assign ram_we    = cmd_i.load && (count_q < CW'(MAX_REQUESTS));

  des_ram #(
    .WIDTH(CYL_BITS),
    .DEPTH(MAX_REQUESTS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(count_q[AW-1:0]),
    .wdata_i(req_ext[CYL_BITS-1:0]),
    .raddr_i(rd_idx_q),
    .rdata_o(rdata)
  );

  // candidate test on the entry read last cycle
  always_comb begin
    cand = 1'b0;
    if (eval_vld_q && !served_q[eval_idx_q]) begin
      if (side_q) begin
        cand = (rdata > start_q) && (!found_q || (rdata < best_q));
      end else begin
        cand = (rdata <= start_q) && (!found_q || (rdata > best_q));
      end
    end
  end

  // seek distance and saturated totals
  always_comb begin
    seek_dist = (best_q >= head_q) ? (best_q - head_q) : (head_q - best_q);
    dist_ext  = 32'(seek_dist);
    best_ext  = 32'(best_q);
    sum       = 33'(total_q) + 33'(dist_ext);
    step_d    = (dist_ext > des_pkg::STEP_MAX) ? 16'hFFFF : dist_ext[15:0];
    total_d   = (sum > des_pkg::TOTAL_MAX) ? 17'h1FFFF : sum[16:0];
  end

  // status toward the controller
  assign stat_o.count_zero = (count_q == '0);
  assign stat_o.rd_last    = (CW'(rd_idx_q) == (n_q - CW'(1)));
  assign stat_o.found      = found_q;
  assign stat_o.last_hit   = ((served_cnt_q + CW'(1)) == n_q);

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q      <= '0;
      n_q          <= '0;
      served_cnt_q <= '0;
      served_q     <= '0;
      rd_idx_q     <= '0;
      eval_idx_q   <= '0;
      eval_vld_q   <= 1'b0;
      found_q      <= 1'b0;
      side_q       <= 1'b0;
      valid_q      <= 1'b0;
    end else begin
      valid_q    <= 1'b0;
      eval_vld_q <= cmd_i.scan_step;
      eval_idx_q <= rd_idx_q;
      // store a request while there is room
      if (ram_we) begin
        count_q <= count_q + CW'(1);
      end
      // start of a run: take the store over and empty it
      if (cmd_i.run) begin
        count_q      <= '0;
        n_q          <= count_q;
        served_cnt_q <= '0;
        served_q     <= '0;
        side_q       <= item_i.move_right;
        if (count_q == '0) begin
          valid_q <= 1'b1;
        end
      end
      // new scan pass
      if (cmd_i.scan_clr) begin
        rd_idx_q <= '0;
        found_q  <= 1'b0;
      end
      if (cmd_i.scan_step) begin
        rd_idx_q <= rd_idx_q + AW'(1);
      end
      if (cand) begin
        found_q <= 1'b1;
      end
      if (cmd_i.switch_side) begin
        side_q <= ~side_q;
      end
      // serve the chosen request
      if (cmd_i.emit) begin
        served_q[best_idx_q] <= 1'b1;
        served_cnt_q         <= served_cnt_q + CW'(1);
        valid_q              <= 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.run) begin
      start_q  <= start_ext[CYL_BITS-1:0];
      head_q   <= start_ext[CYL_BITS-1:0];
      total_q  <= '0;
      result_q <= '{served_cylinder: '0, step_distance: '0, total_movement: '0,
                    empty_run: 1'b1, last: 1'b1};
    end
    if (cand) begin
      best_q     <= rdata;
      best_idx_q <= eval_idx_q;
    end
    if (cmd_i.emit) begin
      head_q   <= best_q;
      total_q  <= total_d;
      result_q <= '{served_cylinder: best_ext[15:0], step_distance: step_d,
                    total_movement: total_d, empty_run: 1'b0,
                    last: stat_o.last_hit};
    end
  end

  assign result_o       = result_q;
  assign result_valid_o = valid_q;

endmodule

`default_nettype wire

// ===== src/disk_elevator_scheduler.sv =====
// top level of the disk elevator scheduler (look scheduling of stored
// cylinder requests); depends on des_pkg, des_ctrl, des_dp, des_ram
//
//   channel   ports                     handshake
//   item in   item_i                    taken when start high and busy low
//   result    result_o                  one cycle, marked by result_valid_o
//
// a run with no requests gives its result in the cycle after it is taken.
// a run over n requests scans the request ram once per served request
// (one ram read a cycle), plus one more pass when the head turns around.
// results leave one at a time and cannot be held off. reset empties the
// store; the ram needs no clearing.
`timescale 1ns / 1ps
`default_nettype none

module disk_elevator_scheduler #(
  parameter int unsigned MAX_REQUESTS = des_pkg::MAX_REQUESTS_DEF,
  parameter int unsigned CYL_BITS     = des_pkg::CYL_BITS_DEF
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start,
  output logic               busy,
  input  wire des_pkg::in_t  item_i,
  output des_pkg::out_t      result_o,
  output logic               result_valid_o
);

  des_pkg::ctrl_cmd_t cmd;
  des_pkg::dp_stat_t  stat;

  // sequencing
  des_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start),
    .item_cmd_i(item_i.cmd),
    .stat_i    (stat),
    .cmd_o     (cmd),
    .busy_o    (busy)
  );

  // storage, scan and arithmetic
  des_dp #(
    .MAX_REQUESTS(MAX_REQUESTS),
    .CYL_BITS    (CYL_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .item_i        (item_i),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .result_o      (result_o),
    .result_valid_o(result_valid_o)
  );

endmodule

`default_nettype wire

// ===== src/des_chk.sv =====
// port level checks of the disk elevator scheduler, bound to the top level
// depends on des_pkg
`timescale 1ns / 1ps
`default_nettype none

module des_chk (
  input wire logic          clk_i,
  input wire logic          rst_ni,
  input wire logic          start,
  input wire logic          busy,
  input wire des_pkg::in_t  item_i,
  input wire des_pkg::out_t result_o,
  input wire logic          result_valid_o
);

  // an empty run result is the last one of its run
  a_empty_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_o.empty_run |-> result_o.last)
    else $error("empty run result without last");

  // an empty run result carries no movement
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_o.empty_run |->
      (result_o.served_cylinder == '0) && (result_o.step_distance == '0) &&
      (result_o.total_movement == '0))
    else $error("empty run result with movement");

  // more results follow a result that is not last, so the block stays busy
  a_more_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !result_o.last |-> busy)
    else $error("idle while a run still has results");

  // a run item either starts work or answers at once
  a_run_reacts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && (item_i.cmd == des_pkg::CMD_RUN) |=> busy || result_valid_o)
    else $error("run item ignored");

  // the running total never falls below the step
  a_total_ge_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (17'(result_o.step_distance) <= result_o.total_movement))
    else $error("total movement below step distance");

endmodule

bind disk_elevator_scheduler des_chk u_des_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start         (start),
  .busy          (busy),
  .item_i        (item_i),
  .result_o      (result_o),
  .result_valid_o(result_valid_o)
);

`default_nettype wire
